>>> rtl/sarc_pkg.sv
// shared types and codes for the seen address refresh cache
package sarc_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned V4_W    = 32;
  localparam int unsigned OUT_W   = 3;

  localparam logic CMD_NOTE   = 1'b0;
  localparam logic CMD_FORGET = 1'b1;

  localparam logic [OUT_W-1:0] OUT_RECENT    = 3'd0;
  localparam logic [OUT_W-1:0] OUT_REFRESHED = 3'd1;
  localparam logic [OUT_W-1:0] OUT_NEW       = 3'd2;
  localparam logic [OUT_W-1:0] OUT_EVICTED   = 3'd3;
  localparam logic [OUT_W-1:0] OUT_CLEARED   = 3'd4;

  // search key and time of the transaction in progress
  typedef struct packed {
    logic              v6;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [TIME_W-1:0] now;
  } key_t;

  // scan status handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              hit;
    logic              recent;
    logic              have_oldest;
    logic [TIME_W-1:0] oldest_stamp;
  } scan_t;

  // entry write broadcast
  typedef struct packed {
    logic              en;
    logic              v6;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [TIME_W-1:0] stamp;
  } wr_t;

endpackage

>>> rtl/sarc_cell.sv
// one table entry with its stage of the search chain
module sarc_cell import sarc_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 9,
  parameter int unsigned CNT_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  key_t              key_i,
  input  logic [TIME_W-1:0] half_i,
  input  logic [CNT_W-1:0]  used_i,
  input  wr_t               wr_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  scan_t             scan_i,
  input  logic [IDX_W-1:0]  oldest_idx_i,
  output scan_t             scan_o,
  output logic [IDX_W-1:0]  oldest_idx_o
);

  logic              v6_q;
  logic [ADDR_W-1:0] hi_q;
  logic [ADDR_W-1:0] lo_q;
  logic [TIME_W-1:0] stamp_q;

  scan_t             scan_d, scan_q;
  logic [IDX_W-1:0]  oldest_idx_d, oldest_idx_q;

  logic              in_use;
  logic              match;
  logic              recent;
  logic              refresh;
  logic [TIME_W-1:0] age;

  assign in_use  = CNT_W'(IDX) < used_i;
  assign match   = scan_i.active && in_use && !scan_i.hit && (v6_q == key_i.v6)
                   && (hi_q == key_i.hi) && (lo_q == key_i.lo);
  assign age     = key_i.now - stamp_q;
  assign recent  = (key_i.now < stamp_q) || (age < half_i);
  assign refresh = match && !recent;

  always_comb begin
    scan_d       = scan_i;
    oldest_idx_d = oldest_idx_i;
    if (match) begin
      scan_d.hit    = 1'b1;
      scan_d.recent = recent;
    end else if (scan_i.active && in_use && !scan_i.hit &&
                 (!scan_i.have_oldest || stamp_q < scan_i.oldest_stamp)) begin
      scan_d.have_oldest  = 1'b1;
      scan_d.oldest_stamp = stamp_q;
      oldest_idx_d        = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oldest_idx_q <= oldest_idx_d;
    if (wr_i.en && wr_idx_i == IDX_W'(IDX)) begin
      v6_q    <= wr_i.v6;
      hi_q    <= wr_i.hi;
      lo_q    <= wr_i.lo;
      stamp_q <= wr_i.stamp;
    end else if (refresh) begin
      stamp_q <= key_i.now;
    end
  end

  assign scan_o       = scan_q;
  assign oldest_idx_o = oldest_idx_q;

endmodule

>>> rtl/seen_address_refresh_cache.sv
// top level: controller, timeout register and the chain of entry cells
//
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_stall_o     cmd_i is_v6_i addr_high_i addr_low_i now_i
// out       output     out_valid_o / out_stall_i   add_needed_o outcome_o
// cfg       input      cfg_we_i                    cfg_wdata_i (block timeout)
//
// a note registers its start flag, the entry cells pass the search status down the chain,
// the end of the chain is latched, then the finish state decides and writes the slot.
// a forget goes straight to the finish state. one transaction is in the chain at a time.
// a new transaction is accepted while the previous result still waits on out_stall_i.
// reset empties the table (use count to zero) and sets the timeout to 3600.
module seen_address_refresh_cache import sarc_pkg::*; #(
  parameter int unsigned ENTRIES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic              is_v6_i,
  input  logic [ADDR_W-1:0] addr_high_i,
  input  logic [ADDR_W-1:0] addr_low_i,
  input  logic [TIME_W-1:0] now_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              add_needed_o,
  output logic [OUT_W-1:0]  outcome_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [TIME_W-1:0] timeout_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              start_q;
  logic              cmd_q;
  key_t              key_q;
  scan_t             res_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic              out_valid_q;
  logic              add_q;
  logic [OUT_W-1:0]  outcome_q;

  logic              in_fire;
  logic              finish;
  logic              add_d;
  logic [OUT_W-1:0]  outcome_d;
  wr_t               wr;
  logic [IDX_W-1:0]  wr_idx;
  logic [TIME_W-1:0] half;

  scan_t             scan   [ENTRIES+1];
  logic [IDX_W-1:0]  oidx   [ENTRIES+1];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign finish     = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign half       = timeout_q >> 1;

  assign scan[0] = '{active: start_q, hit: 1'b0, recent: 1'b0, have_oldest: 1'b0,
                     oldest_stamp: '0};
  assign oidx[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sarc_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (key_q),
      .half_i       (half),
      .used_i       (used_q),
      .wr_i         (wr),
      .wr_idx_i     (wr_idx),
      .scan_i       (scan[g]),
      .oldest_idx_i (oidx[g]),
      .scan_o       (scan[g+1]),
      .oldest_idx_o (oidx[g+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    add_d     = 1'b0;
    outcome_d = OUT_CLEARED;
    wr        = '{en: 1'b0, v6: key_q.v6, hi: key_q.hi, lo: key_q.lo, stamp: key_q.now};
    wr_idx    = res_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (cmd_i == CMD_FORGET) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan[ENTRIES].active) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd_q == CMD_FORGET) begin
          add_d     = 1'b0;
          outcome_d = OUT_CLEARED;
        end else if (res_q.hit) begin
          add_d     = !res_q.recent;
          outcome_d = res_q.recent ? OUT_RECENT : OUT_REFRESHED;
        end else if (used_q < CNT_W'(ENTRIES)) begin
          add_d     = 1'b1;
          outcome_d = OUT_NEW;
          wr.en     = finish;
          wr_idx    = used_q[IDX_W-1:0];
        end else begin
          add_d     = 1'b1;
          outcome_d = OUT_EVICTED;
          wr.en     = finish;
        end
        if (finish) begin
          state_d = ST_IDLE;
          if (cmd_q == CMD_FORGET) begin
            used_d = '0;
          end else if (!res_q.hit && used_q < CNT_W'(ENTRIES)) begin
            used_d = used_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TIME_W'(3600);
      used_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      start_q <= in_fire && (cmd_i == CMD_NOTE);
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= cmd_i;
      key_q.v6   <= is_v6_i;
      key_q.hi   <= is_v6_i ? addr_high_i : '0;
      key_q.lo   <= is_v6_i ? addr_low_i : {{(ADDR_W-V4_W){1'b0}}, addr_low_i[V4_W-1:0]};
      key_q.now  <= now_i;
    end
    if (state_q == ST_SCAN && scan[ENTRIES].active) begin
      res_q     <= scan[ENTRIES];
      res_idx_q <= oidx[ENTRIES];
    end
    if (finish) begin
      add_q     <= add_d;
      outcome_q <= outcome_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign add_needed_o = add_q;
  assign outcome_o    = outcome_q;

endmodule
